// ===== design/c65alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c65alu_pkg
// Shared types and constants for the 6502 register/ALU execute block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c65alu_pkg;

    // Status register bit positions (N V 1 B D I Z C)
    localparam int unsigned FL_N = 7;
    localparam int unsigned FL_V = 6;
    localparam int unsigned FL_U = 5;
    localparam int unsigned FL_B = 4;
    localparam int unsigned FL_D = 3;
    localparam int unsigned FL_I = 2;
    localparam int unsigned FL_Z = 1;
    localparam int unsigned FL_C = 0;

    localparam logic [7:0] SP_RESET    = 8'hFF;
    localparam logic [7:0] FLAGS_RESET = 8'h10;
    localparam logic [7:0] STATUS_ONE  = 8'h20;

    // Operation codes
    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_ADC = 6'd3,
        OP_SBC = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
        OP_ORA = 6'd8,  OP_AND = 6'd9,  OP_EOR = 6'd10, OP_ASL = 6'd11,
        OP_LSR = 6'd12, OP_ROL = 6'd13, OP_ROR = 6'd14, OP_CLC = 6'd15,
        OP_SEC = 6'd16, OP_CLV = 6'd17, OP_CLD = 6'd18, OP_SED = 6'd19,
        OP_CLI = 6'd20, OP_SEI = 6'd21, OP_INX = 6'd22, OP_DEX = 6'd23,
        OP_INY = 6'd24, OP_DEY = 6'd25, OP_TAX = 6'd26, OP_TXA = 6'd27,
        OP_TAY = 6'd28, OP_TYA = 6'd29, OP_TXS = 6'd30, OP_TSX = 6'd31,
        OP_NOP = 6'd32
    } t_op;

    // Request: one decoded operation
    typedef struct packed {
        logic [5:0] opcode;
        logic [7:0] operand;
        logic       on_memory;
    } t_req;

    // Result of one operation
    typedef struct packed {
        logic [7:0] result;
        logic [7:0] status;
        logic       write_back;
    } t_rsp;

    // Architectural register file
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] s;
        logic [7:0] p;
    } t_regs;

endpackage

`default_nettype wire

// ===== design/c65alu_exec.sv =====
// ----------------------------------------------------------------------------
// c65alu_exec
// Combinational execute: computes the response and next register file for
// one request from the current register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c65alu_exec
    import c65alu_pkg::*;
(
    input  wire t_req  i_req,
    input  wire t_regs i_regs,
    output t_regs      o_regs,
    output t_rsp       o_rsp
);

    logic [7:0] w_add_r;
    logic [7:0] w_add_m;
    logic       w_add_c;
    logic [8:0] w_sum;
    logic       w_ovf;
    logic [7:0] w_sh_src;
    logic [7:0] w_sh_res;
    logic       w_sh_c;
    logic [7:0] w_res;
    logic [7:0] w_nz_val;
    logic       w_set_nz;
    logic       w_wb;
    t_regs      w_next;

    // Select adder operands: ADC adds M, everything else adds ~M
    always_comb begin
        w_add_r = i_regs.a;
        w_add_m = ~i_req.operand;
        w_add_c = 1'b1;
        case (i_req.opcode)
            OP_ADC: begin
                w_add_m = i_req.operand;
                w_add_c = i_regs.p[FL_C];
            end
            OP_SBC: w_add_c = i_regs.p[FL_C];
            OP_CPX: w_add_r = i_regs.x;
            OP_CPY: w_add_r = i_regs.y;
            default: ;
        endcase
    end

    // Byte adder with carry and overflow
    assign w_sum = {1'b0, w_add_r} + {1'b0, w_add_m} + {8'd0, w_add_c};
    assign w_ovf = ((w_add_r[7] ^ w_sum[7]) & (w_add_m[7] ^ w_sum[7]));

    // Shifter on A or on the memory byte
    assign w_sh_src = i_req.on_memory ? i_req.operand : i_regs.a;
    always_comb begin
        case (i_req.opcode)
            OP_ASL: begin
                w_sh_res = {w_sh_src[6:0], 1'b0};
                w_sh_c   = w_sh_src[7];
            end
            OP_LSR: begin
                w_sh_res = {1'b0, w_sh_src[7:1]};
                w_sh_c   = w_sh_src[0];
            end
            OP_ROL: begin
                w_sh_res = {w_sh_src[6:0], i_regs.p[FL_C]};
                w_sh_c   = w_sh_src[7];
            end
            default: begin
                w_sh_res = {i_regs.p[FL_C], w_sh_src[7:1]};
                w_sh_c   = w_sh_src[0];
            end
        endcase
    end

    // Decode the operation into register and flag updates
    always_comb begin
        w_next   = i_regs;
        w_res    = 8'd0;
        w_nz_val = 8'd0;
        w_set_nz = 1'b0;
        w_wb     = 1'b0;
        case (i_req.opcode)
            OP_LDA: begin
                w_next.a = i_req.operand;
                w_res    = i_req.operand;
                w_set_nz = 1'b1;
            end
            OP_LDX: begin
                w_next.x = i_req.operand;
                w_res    = i_req.operand;
                w_set_nz = 1'b1;
            end
            OP_LDY: begin
                w_next.y = i_req.operand;
                w_res    = i_req.operand;
                w_set_nz = 1'b1;
            end
            OP_ADC, OP_SBC: begin
                w_next.a       = w_sum[7:0];
                w_res          = w_sum[7:0];
                w_set_nz       = 1'b1;
                w_next.p[FL_C] = w_sum[8];
                w_next.p[FL_V] = w_ovf;
            end
            OP_CMP, OP_CPX, OP_CPY: begin
                w_res          = w_sum[7:0];
                w_set_nz       = 1'b1;
                w_next.p[FL_C] = w_sum[8];
            end
            OP_ORA: begin
                w_res    = i_regs.a | i_req.operand;
                w_next.a = w_res;
                w_set_nz = 1'b1;
            end
            OP_AND: begin
                w_res    = i_regs.a & i_req.operand;
                w_next.a = w_res;
                w_set_nz = 1'b1;
            end
            OP_EOR: begin
                w_res    = i_regs.a ^ i_req.operand;
                w_next.a = w_res;
                w_set_nz = 1'b1;
            end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                w_res          = w_sh_res;
                w_set_nz       = 1'b1;
                w_next.p[FL_C] = w_sh_c;
                if (i_req.on_memory) begin
                    w_wb = 1'b1;
                end else begin
                    w_next.a = w_sh_res;
                end
            end
            OP_CLC: w_next.p[FL_C] = 1'b0;
            OP_SEC: w_next.p[FL_C] = 1'b1;
            OP_CLV: w_next.p[FL_V] = 1'b0;
            OP_CLD: w_next.p[FL_D] = 1'b0;
            OP_SED: w_next.p[FL_D] = 1'b1;
            OP_CLI: w_next.p[FL_I] = 1'b0;
            OP_SEI: w_next.p[FL_I] = 1'b1;
            OP_INX: begin
                w_res    = i_regs.x + 8'd1;
                w_next.x = w_res;
                w_set_nz = 1'b1;
            end
            OP_DEX: begin
                w_res    = i_regs.x - 8'd1;
                w_next.x = w_res;
                w_set_nz = 1'b1;
            end
            OP_INY: begin
                w_res    = i_regs.y + 8'd1;
                w_next.y = w_res;
                w_set_nz = 1'b1;
            end
            OP_DEY: begin
                w_res    = i_regs.y - 8'd1;
                w_next.y = w_res;
                w_set_nz = 1'b1;
            end
            OP_TAX: begin
                w_res    = i_regs.a;
                w_next.x = w_res;
                w_set_nz = 1'b1;
            end
            OP_TXA: begin
                w_res    = i_regs.x;
                w_next.a = w_res;
                w_set_nz = 1'b1;
            end
            OP_TAY: begin
                w_res    = i_regs.a;
                w_next.y = w_res;
                w_set_nz = 1'b1;
            end
            OP_TYA: begin
                w_res    = i_regs.y;
                w_next.a = w_res;
                w_set_nz = 1'b1;
            end
            OP_TXS: begin
                w_res    = i_regs.x;
                w_next.s = w_res;
            end
            OP_TSX: begin
                w_res    = i_regs.s;
                w_next.x = w_res;
                w_set_nz = 1'b1;
            end
            default: ;
        endcase
        w_nz_val = w_res;
        // Update N and Z from the produced byte
        if (w_set_nz) begin
            w_next.p[FL_N] = w_nz_val[7];
            w_next.p[FL_Z] = (w_nz_val == 8'd0);
        end
    end

    assign o_regs           = w_next;
    assign o_rsp.result     = w_res;
    assign o_rsp.status     = w_next.p | STATUS_ONE;
    assign o_rsp.write_back = w_wb;

endmodule

`default_nettype wire

// ===== design/c65alu_regfile.sv =====
// ----------------------------------------------------------------------------
// c65alu_regfile
// Architectural registers A, X, Y, S and P, updated once per executed request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c65alu_regfile
    import c65alu_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire t_regs i_regs,
    output t_regs      o_regs
);

    t_regs r_regs;

    // Load the next register file when a request executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.a <= 8'd0;
            r_regs.x <= 8'd0;
            r_regs.y <= 8'd0;
            r_regs.s <= SP_RESET;
            r_regs.p <= FLAGS_RESET;
        end else if (i_en) begin
            r_regs <= i_regs;
        end
    end

    assign o_regs = r_regs;

    // Registers hold while nothing executes
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_regs))
        else $error("register file changed without an executed request");

    // Reset leaves the documented register values
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_regs.s == SP_RESET && r_regs.p == FLAGS_RESET
                      && r_regs.a == 8'd0))
        else $error("register file reset value wrong");

    // Bit 5 of the stored flags is never set by execution
    a_u_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> !r_regs.p[FL_U])
        else $error("stored flags picked up bit 5");

endmodule

`default_nettype wire

// ===== design/cpu6502_alu_register_execute.sv =====
// ----------------------------------------------------------------------------
// cpu6502_alu_register_execute
// 6502 register and ALU execute stage: loads, ADC/SBC, compares, logic ops,
// shifts and rotates, flag ops, inc/dec, transfers and NOP.
// ----------------------------------------------------------------------------
// Path: a request passes the input register, then the response register; an
//   output stall holds it in the input register.
// Throughput: 1 request per cycle while the output is not stalled; the
//   register file loop through the byte adder and flag logic is combinational.
// Reset: synchronous, active low; A, X, Y = 0, S = 0xFF, flags = 0x10,
//   both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none

module cpu6502_alu_register_execute
    import c65alu_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_rsp      o_out
);

    logic  r_in_valid;
    t_req  r_in;
    logic  r_out_valid;
    t_rsp  r_out;
    logic  w_fire;
    logic  w_in_take;
    t_regs w_regs;
    t_regs w_regs_next;
    t_rsp  w_rsp;

    // Execute when a request is staged and the response register can take it
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in;
        end
    end

    c65alu_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_fire),
        .i_regs  (w_regs_next),
        .o_regs  (w_regs)
    );

    c65alu_exec u_exec (
        .i_req  (r_in),
        .i_regs (w_regs),
        .o_regs (w_regs_next),
        .o_rsp  (w_rsp)
    );

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Never overwrite a response that is still stalled
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !w_fire)
        else $error("response overwritten while stalled");

    // Write-back only comes from a shift
    a_wb_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && w_rsp.write_back |->
            (r_in.opcode == OP_ASL || r_in.opcode == OP_LSR
             || r_in.opcode == OP_ROL || r_in.opcode == OP_ROR))
        else $error("write-back on a non-shift request");

    // Reported status always carries bit 5
    a_status_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status[FL_U])
        else $error("status bit 5 clear");

endmodule

`default_nettype wire

// ===== tb/sv/cpu6502_alu_register_execute_tb.sv =====
// ----------------------------------------------------------------------------
// cpu6502_alu_register_execute_tb
// Self-checking testbench for the 6502 register/ALU execute stage. Directed
// requests cover every operation, register wrap, overflow, borrow and the
// unused opcodes. Random traffic follows, with bursts of idle on both sides,
// one long output hold that backs the block up, and a final stretch at full
// rate. A local model of the register file predicts every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu6502_alu_register_execute_tb;
    import c65alu_pkg::*;

    localparam logic [5:0] OP_UNUSED_LO = 6'd33;
    localparam logic [5:0] OP_UNUSED_HI = 6'd63;
    localparam int         HOLD_CYCLES  = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_rsp o_out;

    // Model register file
    logic [7:0] acc_q;
    logic [7:0] x_q;
    logic [7:0] y_q;
    logic [7:0] sp_q;
    logic [7:0] flags_q;

    t_rsp pending_rsp[$];
    int   error_count = 0;

    // Idle control for the sender (tx) and for the receiver (rx, hold)
    bit   tx_idle_en = 1'b0;
    bit   rx_idle_en = 1'b0;
    int   tx_quiet = 0;
    int   rx_burst = 0;
    int   rx_quiet = 0;
    bit   hold_request = 1'b0;
    bit   hold_taken = 1'b0;
    int   hold_left = 0;

    cpu6502_alu_register_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Set N and Z from a byte and pass it through
    function automatic logic [7:0] upd_nz(input logic [7:0] v);
        flags_q[FL_Z] = (v == 8'h00);
        flags_q[FL_N] = v[7];
        return v;
    endfunction

    // Binary add with carry in; V only for ADC/SBC
    function automatic logic [7:0] add_bytes(input logic [7:0] r, input logic [7:0] m,
                                             input logic cin, input bit with_v);
        logic [8:0] sum;
        logic [7:0] b;
        sum = {1'b0, r} + {1'b0, m} + {8'd0, cin};
        b = upd_nz(sum[7:0]);
        flags_q[FL_C] = sum[8];
        if (with_v) begin
            flags_q[FL_V] = (r[7] ^ b[7]) & (m[7] ^ b[7]);
        end
        return b;
    endfunction

    function automatic logic [7:0] shift_byte(input logic [5:0] op, input logic [7:0] v);
        logic       c_in;
        logic [7:0] r;
        c_in = flags_q[FL_C];
        case (op)
            OP_ASL: begin
                flags_q[FL_C] = v[7];
                r = {v[6:0], 1'b0};
            end
            OP_LSR: begin
                flags_q[FL_C] = v[0];
                r = {1'b0, v[7:1]};
            end
            OP_ROL: begin
                flags_q[FL_C] = v[7];
                r = {v[6:0], c_in};
            end
            default: begin
                flags_q[FL_C] = v[0];
                r = {c_in, v[7:1]};
            end
        endcase
        return upd_nz(r);
    endfunction

    // Execute one request on the model registers and build the response
    function automatic t_rsp execute_op(input t_req r);
        t_rsp       o;
        logic [7:0] m;
        m = r.operand;
        o = '0;
        case (r.opcode)
            OP_LDA: begin acc_q = upd_nz(m); o.result = acc_q; end
            OP_LDX: begin x_q = upd_nz(m); o.result = x_q; end
            OP_LDY: begin y_q = upd_nz(m); o.result = y_q; end
            OP_ADC: begin
                acc_q = add_bytes(acc_q, m, flags_q[FL_C], 1'b1);
                o.result = acc_q;
            end
            OP_SBC: begin
                acc_q = add_bytes(acc_q, ~m, flags_q[FL_C], 1'b1);
                o.result = acc_q;
            end
            OP_CMP: o.result = add_bytes(acc_q, ~m, 1'b1, 1'b0);
            OP_CPX: o.result = add_bytes(x_q, ~m, 1'b1, 1'b0);
            OP_CPY: o.result = add_bytes(y_q, ~m, 1'b1, 1'b0);
            OP_ORA: begin acc_q = upd_nz(acc_q | m); o.result = acc_q; end
            OP_AND: begin acc_q = upd_nz(acc_q & m); o.result = acc_q; end
            OP_EOR: begin acc_q = upd_nz(acc_q ^ m); o.result = acc_q; end
            OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
                if (r.on_memory) begin
                    o.result = shift_byte(r.opcode, m);
                    o.write_back = 1'b1;
                end else begin
                    acc_q = shift_byte(r.opcode, acc_q);
                    o.result = acc_q;
                end
            end
            OP_CLC: flags_q[FL_C] = 1'b0;
            OP_SEC: flags_q[FL_C] = 1'b1;
            OP_CLV: flags_q[FL_V] = 1'b0;
            OP_CLD: flags_q[FL_D] = 1'b0;
            OP_SED: flags_q[FL_D] = 1'b1;
            OP_CLI: flags_q[FL_I] = 1'b0;
            OP_SEI: flags_q[FL_I] = 1'b1;
            OP_INX: begin x_q = upd_nz(x_q + 8'd1); o.result = x_q; end
            OP_DEX: begin x_q = upd_nz(x_q - 8'd1); o.result = x_q; end
            OP_INY: begin y_q = upd_nz(y_q + 8'd1); o.result = y_q; end
            OP_DEY: begin y_q = upd_nz(y_q - 8'd1); o.result = y_q; end
            OP_TAX: begin x_q = upd_nz(acc_q); o.result = x_q; end
            OP_TXA: begin acc_q = upd_nz(x_q); o.result = acc_q; end
            OP_TAY: begin y_q = upd_nz(acc_q); o.result = y_q; end
            OP_TYA: begin acc_q = upd_nz(y_q); o.result = acc_q; end
            OP_TXS: begin sp_q = x_q; o.result = sp_q; end
            OP_TSX: begin x_q = upd_nz(sp_q); o.result = x_q; end
            default: ;
        endcase
        o.status = flags_q | STATUS_ONE;
        return o;
    endfunction

    function automatic t_req make_req(input logic [5:0] op, input logic [7:0] m,
                                      input logic mem);
        t_req r;
        r.opcode = op;
        r.operand = m;
        r.on_memory = mem;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, optionally after an idle burst, and hold it until taken
    task automatic send_op(input t_req r);
        int gap;
        if (tx_idle_en && tx_quiet == 0 && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            tx_quiet = $urandom_range(0, 40);
        end else if (tx_quiet > 0) begin
            tx_quiet--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= r;
        do @(posedge i_clk); while (o_in_stall);
        pending_rsp.push_back(execute_op(r));
    endtask

    // Random request, mostly defined opcodes, operands biased toward edges
    task automatic send_random_op();
        logic [5:0] op;
        logic [7:0] m;
        logic       mem;
        if ($urandom_range(0, 9) == 0) begin
            op = 6'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end else begin
            op = 6'($urandom_range(OP_LDA, OP_NOP));
        end
        case ($urandom_range(0, 7))
            0: m = 8'h00;
            1: m = 8'hFF;
            2: m = 8'h80;
            3: m = 8'h7F;
            default: m = 8'($urandom_range(0, 255));
        endcase
        mem = 1'($urandom_range(0, 1));
        send_op(make_req(op, m, mem));
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Drive output stall: long hold on request, otherwise random bursts
    always @(negedge i_clk) begin
        if (hold_request && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
        end else if (!hold_request) begin
            hold_taken = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_out_stall <= 1'b1;
        end else if (rx_quiet > 0) begin
            rx_quiet--;
            i_out_stall <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
            rx_burst = $urandom_range(0, 11);
            rx_quiet = $urandom_range(0, 40);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted response with the oldest prediction
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_rsp.size() == 0) begin
                error_count++;
                $display("%0t: unexpected response result=%02h status=%02h wb=%0b",
                         $time, o_out.result, o_out.status, o_out.write_back);
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_out.result !== exp_rsp.result) begin
                    error_count++;
                    $display("%0t: result mismatch expected=%02h actual=%02h",
                             $time, exp_rsp.result, o_out.result);
                end
                if (o_out.status !== exp_rsp.status) begin
                    error_count++;
                    $display("%0t: status mismatch expected=%02h actual=%02h",
                             $time, exp_rsp.status, o_out.status);
                end
                if (o_out.write_back !== exp_rsp.write_back) begin
                    error_count++;
                    $display("%0t: write_back mismatch expected=%0b actual=%0b",
                             $time, exp_rsp.write_back, o_out.write_back);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Index wrap and stack transfers straight out of reset
    task automatic test_index_wrap();
        send_op(make_req(OP_TSX, 8'h00, 1'b0));
        send_op(make_req(OP_INX, 8'hFF, 1'b1));
        send_op(make_req(OP_DEX, 8'h00, 1'b0));
        send_op(make_req(OP_TXS, 8'h00, 1'b0));
        send_op(make_req(OP_INY, 8'h00, 1'b0));
        send_op(make_req(OP_DEY, 8'h00, 1'b0));
        send_op(make_req(OP_DEY, 8'h00, 1'b0));
    endtask

    // Signed overflow, borrow and compare ordering
    task automatic test_arithmetic();
        send_op(make_req(OP_LDA, 8'h7F, 1'b0));
        send_op(make_req(OP_ADC, 8'h01, 1'b0));
        send_op(make_req(OP_SEC, 8'h00, 1'b0));
        send_op(make_req(OP_SBC, 8'h01, 1'b0));
        send_op(make_req(OP_ADC, 8'hFF, 1'b0));
        send_op(make_req(OP_CMP, 8'h7F, 1'b0));
        send_op(make_req(OP_CPX, 8'h00, 1'b0));
        send_op(make_req(OP_CPY, 8'hFF, 1'b0));
        send_op(make_req(OP_LDX, 8'h00, 1'b1));
        send_op(make_req(OP_LDY, 8'h80, 1'b0));
    endtask

    // Logic ops, shifts on both targets, flag ops, transfers, NOP and unused opcodes
    task automatic test_logic_shift_flags();
        send_op(make_req(OP_ORA, 8'h80, 1'b0));
        send_op(make_req(OP_AND, 8'h00, 1'b0));
        send_op(make_req(OP_EOR, 8'hFF, 1'b0));
        send_op(make_req(OP_ASL, 8'h00, 1'b0));
        send_op(make_req(OP_ROL, 8'h80, 1'b1));
        send_op(make_req(OP_ROR, 8'h00, 1'b0));
        send_op(make_req(OP_LSR, 8'h01, 1'b1));
        send_op(make_req(OP_CLC, 8'h00, 1'b0));
        send_op(make_req(OP_CLV, 8'h00, 1'b0));
        send_op(make_req(OP_SED, 8'h00, 1'b0));
        send_op(make_req(OP_CLD, 8'h00, 1'b0));
        send_op(make_req(OP_SEI, 8'h00, 1'b0));
        send_op(make_req(OP_CLI, 8'h00, 1'b0));
        send_op(make_req(OP_TAX, 8'h00, 1'b0));
        send_op(make_req(OP_TXA, 8'h00, 1'b0));
        send_op(make_req(OP_TAY, 8'h00, 1'b0));
        send_op(make_req(OP_TYA, 8'h00, 1'b0));
        send_op(make_req(OP_NOP, 8'hFF, 1'b1));
        send_op(make_req(OP_UNUSED_LO, 8'hFF, 1'b1));
        send_op(make_req(OP_UNUSED_HI, 8'h00, 1'b0));
    endtask

    task automatic test_random_traffic(input int n);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (n) send_random_op();
    endtask

    // Hold the output long enough that the block backs up and stalls its input
    task automatic test_backpressure(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_request = 1'b1;
        repeat (n) send_random_op();
        hold_request = 1'b0;
    endtask

    // No idling on either side: drop any stall burst still running
    task automatic test_full_rate(input int n);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        rx_burst = 0;
        repeat (n) send_random_op();
    endtask

    initial begin
        acc_q = 8'h00;
        x_q = 8'h00;
        y_q = 8'h00;
        sp_q = SP_RESET;
        flags_q = FLAGS_RESET;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_index_wrap();
        test_arithmetic();
        test_logic_shift_flags();
        test_random_traffic(1200);
        test_backpressure(40);
        test_random_traffic(60);
        test_full_rate(300);

        // Drain, then let the pipeline settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_rsp.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("cpu6502_alu_register_execute regression: pass");
        end else begin
            $display("cpu6502_alu_register_execute regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("cpu6502_alu_register_execute regression: fail");
        $finish;
    end

endmodule
